// File: hdl/page_table_map_walker_defines.svh
// ----------------------------------------------------------------------------
// page_table_map_walker_defines
// Assertion macros used by the page table walker.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAP_WALKER_DEFINES_SVH
`define PAGE_TABLE_MAP_WALKER_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is low
`define PTW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define PTW_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PTW_ASSERT(lbl, clk, rstn, prop, msg)
`define PTW_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Field widths, status codes and shared types of the page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned VA_W     = 39;
  localparam int unsigned SIZE_W   = 39;
  localparam int unsigned PA_W     = 56;
  localparam int unsigned PERM_W   = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEAF_W   = 54;
  localparam int unsigned PPN_W    = 44;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned ENTRIES  = 512;
  localparam int unsigned OFS_W    = 12;
  localparam int unsigned VPN_W    = 28;
  localparam int unsigned LAST_W   = 40;
  localparam int unsigned ALU_W    = 44;

  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_VA_RANGE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAGES   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd5;

  localparam logic [1:0] LVL_TOP  = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  localparam logic [PERM_W-1:0] VALID_BIT = 10'd1;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

  // 9-bit table index of a virtual page number at one level
  function automatic logic [IDX_W-1:0] level_index(logic [VPN_W-1:0] vpn, logic [1:0] level);
    logic [IDX_W-1:0] idx;
    unique case (level)
      LVL_TOP:  idx = vpn[26:18];
      LVL_MID:  idx = vpn[17:9];
      default:  idx = vpn[8:0];
    endcase
    return idx;
  endfunction

endpackage

// File: hdl/ptw_if.sv
// ----------------------------------------------------------------------------
// ptw_if
// Command and response channels of the page table walker.
// ----------------------------------------------------------------------------
interface ptw_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [ptw_pkg::VA_W-1:0]    va;
  logic [ptw_pkg::SIZE_W-1:0]  size_bytes;
  logic [ptw_pkg::PA_W-1:0]    pa;
  logic [ptw_pkg::PERM_W-1:0]  perm;

  modport source (output valid, command, va, size_bytes, pa, perm, input ready);
  modport sink   (input valid, command, va, size_bytes, pa, perm, output ready);
endinterface

interface ptw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptw_pkg::STATUS_W-1:0]  status;
  logic [ptw_pkg::LEAF_W-1:0]    leaf_entry;

  modport source (output valid, status, leaf_entry, input ready);
  modport sink   (input valid, status, leaf_entry, output ready);
endinterface

// File: hdl/page_table_map_walker.sv
// ----------------------------------------------------------------------------
// page_table_map_walker
// Three-level radix page table engine: maps page ranges and looks up leaves.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  ---------+-----+----------------------------------------------
//  cmd_i    | in  | command, va, size_bytes, pa, perm
//  rsp_o    | out | status, leaf_entry
//  cfg      | in  | cfg_we_i, cfg_wdata_i (table_base_page)
//
//  after reset the store is swept to zero, cmd_i not ready meanwhile
//  lookup: per level a store read, then a check (S_RD, S_CHK), plus accept and reply
//  map: setup finds the range end (S_SUM1, S_SUM2), each page is walked from the top,
//  each new directory page is zeroed (S_PCLR) and linked (S_LINK); one store port
//  and one shared adder serialise these steps. One item at a time; a finished reply
//  waits in the output register while the next item is accepted, and the block stalls only when a second reply is ready
`include "page_table_map_walker_defines.svh"

module page_table_map_walker #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ptw_pkg::PPN_W-1:0]  cfg_wdata_i,
  ptw_cmd_if.sink                    cmd_i,
  ptw_rsp_if.source                  rsp_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_PAGES);
  localparam int unsigned CNT_W  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned ADDR_W = SLOT_W + ptw_pkg::IDX_W;
  localparam int unsigned DEPTH  = TABLE_PAGES * ptw_pkg::ENTRIES;
  localparam int unsigned AluW   = ptw_pkg::ALU_W;

  localparam logic [ptw_pkg::ALU_W-1:0] PAGES_A   = AluW'(TABLE_PAGES);
  localparam logic [CNT_W-1:0]          PAGES_C   = CNT_W'(TABLE_PAGES);
  localparam logic [ADDR_W-1:0]         LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SUM1  = 4'd2;
  localparam logic [3:0] S_SUM2  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_PCLR  = 4'd6;
  localparam logic [3:0] S_LINK  = 4'd7;
  localparam logic [3:0] S_PAINC = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                      state_q, state_d;
  logic [ADDR_W-1:0]               clr_q, clr_d;
  logic [ptw_pkg::PPN_W-1:0]       base_q;
  logic [CNT_W-1:0]                free_q, free_d;
  logic                            rsp_valid_q, rsp_valid_d;

  logic                            lookup_q, lookup_d;
  logic [ptw_pkg::SIZE_W-1:0]      size_q, size_d;
  logic [ptw_pkg::LAST_W-1:0]      last_q, last_d;
  logic [ptw_pkg::VPN_W-1:0]       vpn_q, vpn_d;
  logic [ptw_pkg::PPN_W-1:0]       ppn_q, ppn_d;
  logic [ptw_pkg::PERM_W-1:0]      perm_q, perm_d;
  logic [1:0]                      level_q, level_d;
  logic [SLOT_W-1:0]               slot_q, slot_d;
  logic [ptw_pkg::STATUS_W-1:0]    res_status_q, res_status_d;
  logic [ptw_pkg::LEAF_W-1:0]      res_leaf_q, res_leaf_d;
  logic [ptw_pkg::STATUS_W-1:0]    out_status_q, out_status_d;
  logic [ptw_pkg::LEAF_W-1:0]      out_leaf_q, out_leaf_d;

  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_addr;
  logic [ptw_pkg::LEAF_W-1:0]      mem_wdata;
  logic [ptw_pkg::LEAF_W-1:0]      mem_rdata;

  ptw_pkg::alu_req_t               alu_req;
  ptw_pkg::alu_rsp_t               alu_rsp;

  logic                            entry_valid;
  logic [ptw_pkg::PPN_W-1:0]       entry_ppn;

  assign entry_valid = mem_rdata[0];
  assign entry_ppn   = mem_rdata[ptw_pkg::LEAF_W-1:ptw_pkg::PERM_W];

  ptw_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH),
    .DATA_W (ptw_pkg::LEAF_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  ptw_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign cmd_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.leaf_entry = out_leaf_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_d       = free_q;
    rsp_valid_d  = rsp_valid_q;
    lookup_d     = lookup_q;
    size_d       = size_q;
    last_d       = last_q;
    vpn_d        = vpn_q;
    ppn_d        = ppn_q;
    perm_d       = perm_q;
    level_d      = level_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_leaf_d   = res_leaf_q;
    out_status_d = out_status_q;
    out_leaf_d   = out_leaf_q;

    mem_we    = 1'b0;
    mem_addr  = {slot_q, ptw_pkg::level_index(vpn_q, level_q)};
    mem_wdata = '0;
    alu_req   = '{a: '0, b: '0, sub: 1'b0};

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_i.valid) begin
          lookup_d   = (cmd_i.command == ptw_pkg::CMD_LOOKUP);
          size_d     = cmd_i.size_bytes;
          last_d     = {1'b0, cmd_i.va};
          vpn_d      = {1'b0, cmd_i.va[ptw_pkg::VA_W-1:ptw_pkg::OFS_W]};
          ppn_d      = cmd_i.pa[ptw_pkg::PA_W-1:ptw_pkg::OFS_W];
          perm_d     = cmd_i.perm;
          level_d    = ptw_pkg::LVL_TOP;
          slot_d     = '0;
          res_leaf_d = '0;
          if (cmd_i.command == ptw_pkg::CMD_LOOKUP) begin
            state_d = S_RD;
          end else if (cmd_i.size_bytes == '0) begin
            res_status_d = ptw_pkg::ST_ZERO_SIZE;
            state_d      = S_DONE;
          end else begin
            state_d = S_SUM1;
          end
        end
      end
      S_SUM1: begin
        alu_req.a = AluW'(last_q);
        alu_req.b = AluW'(size_q);
        last_d    = alu_rsp.sum[ptw_pkg::LAST_W-1:0];
        state_d   = S_SUM2;
      end
      S_SUM2: begin
        // last byte of the range, its page is where the map stops
        alu_req.a   = AluW'(last_q);
        alu_req.b   = AluW'(1);
        alu_req.sub = 1'b1;
        last_d      = alu_rsp.sum[ptw_pkg::LAST_W-1:0];
        state_d     = S_RD;
      end
      S_RD: begin
        if (vpn_q[ptw_pkg::VPN_W-1:ptw_pkg::VPN_W-2] != 2'b00) begin
          res_status_d = ptw_pkg::ST_VA_RANGE;
          state_d      = S_DONE;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (level_q != ptw_pkg::LVL_LEAF) begin
          if (entry_valid) begin
            // pointer must land inside the store
            alu_req.a   = entry_ppn;
            alu_req.b   = base_q;
            alu_req.sub = 1'b1;
            if (!alu_rsp.carry || (alu_rsp.sum >= PAGES_A)) begin
              res_status_d = ptw_pkg::ST_NO_PAGES;
              state_d      = S_DONE;
            end else begin
              slot_d  = alu_rsp.sum[SLOT_W-1:0];
              level_d = level_q - 2'd1;
              state_d = S_RD;
            end
          end else if (lookup_q) begin
            res_status_d = ptw_pkg::ST_NOT_MAPPED;
            state_d      = S_DONE;
          end else if (free_q >= PAGES_C) begin
            res_status_d = ptw_pkg::ST_NO_PAGES;
            state_d      = S_DONE;
          end else begin
            clr_d   = {free_q[SLOT_W-1:0], {ptw_pkg::IDX_W{1'b0}}};
            state_d = S_PCLR;
          end
        end else if (lookup_q) begin
          if (entry_valid) begin
            res_leaf_d   = mem_rdata;
            res_status_d = ptw_pkg::ST_OK;
          end else begin
            res_status_d = ptw_pkg::ST_NOT_MAPPED;
          end
          state_d = S_DONE;
        end else if (entry_valid) begin
          res_status_d = ptw_pkg::ST_MAPPED;
          state_d      = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {ppn_q, perm_q | ptw_pkg::VALID_BIT};
          if (vpn_q == last_q[ptw_pkg::LAST_W-1:ptw_pkg::OFS_W]) begin
            res_status_d = ptw_pkg::ST_OK;
            state_d      = S_DONE;
          end else begin
            alu_req.a = AluW'(vpn_q);
            alu_req.b = AluW'(1);
            vpn_d     = alu_rsp.sum[ptw_pkg::VPN_W-1:0];
            state_d   = S_PAINC;
          end
        end
      end
      S_PCLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + ADDR_W'(1);
        if (clr_q[ptw_pkg::IDX_W-1:0] == '1) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        // directory entry written after the fresh page is zeroed
        alu_req.a = base_q;
        alu_req.b = AluW'(free_q);
        mem_we    = 1'b1;
        mem_wdata = {alu_rsp.sum, ptw_pkg::VALID_BIT};
        slot_d    = free_q[SLOT_W-1:0];
        free_d    = free_q + CNT_W'(1);
        level_d   = level_q - 2'd1;
        state_d   = S_RD;
      end
      S_PAINC: begin
        alu_req.a = ppn_q;
        alu_req.b = AluW'(1);
        ppn_d     = alu_rsp.sum;
        level_d   = ptw_pkg::LVL_TOP;
        slot_d    = '0;
        state_d   = S_RD;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_leaf_d   = res_leaf_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      free_q      <= CNT_W'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lookup_q     <= lookup_d;
    size_q       <= size_d;
    last_q       <= last_d;
    vpn_q        <= vpn_d;
    ppn_q        <= ppn_d;
    perm_q       <= perm_d;
    level_q      <= level_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_leaf_q   <= res_leaf_d;
    out_status_q <= out_status_d;
    out_leaf_q   <= out_leaf_d;
  end

  `PTW_ASSERT(a_free_bound, clk_i, rst_ni, free_q <= PAGES_C, "slot pointer past store")
  `PTW_ASSERT(a_link_room, clk_i, rst_ni, (state_q == S_LINK) |-> (free_q < PAGES_C), "alloc with no slot left")
  `PTW_ASSERT(a_wr_in_range, clk_i, rst_ni, mem_we |-> (ADDR_W'(mem_addr) <= LAST_ADDR), "store write out of range")
  `PTW_ASSERT(a_busy_after_accept, clk_i, rst_ni, (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready, "item accepted while busy")
  `PTW_ASSERT(a_rsp_from_done, clk_i, rst_ni, $rose(rsp_valid_q) |-> ($past(state_q) == S_DONE), "reply without finished item")

endmodule

// File: hdl/ptw_alu.sv
// ----------------------------------------------------------------------------
// ptw_alu
// Shared add/subtract unit used by the add and subtract steps of the walk sequencer.
// ----------------------------------------------------------------------------
module ptw_alu (
  input  ptw_pkg::alu_req_t req_i,
  output ptw_pkg::alu_rsp_t rsp_o
);

  logic [ptw_pkg::ALU_W:0] full;

  // subtract is a + ~b + 1; carry set means no borrow
  assign full = {1'b0, req_i.a}
              + {1'b0, req_i.b ^ {ptw_pkg::ALU_W{req_i.sub}}}
              + {{ptw_pkg::ALU_W{1'b0}}, req_i.sub};

  assign rsp_o.sum   = full[ptw_pkg::ALU_W-1:0];
  assign rsp_o.carry = full[ptw_pkg::ALU_W];

endmodule

// File: hdl/ptw_store.sv
// ----------------------------------------------------------------------------
// ptw_store
// Single-port table store, read-first, registered read data.
// ----------------------------------------------------------------------------
module ptw_store #(
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned DATA_W = 54
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/page_table_map_walker_test.sv
// ----------------------------------------------------------------------------
// page_table_map_walker_test
// Self-checking bench for the page table walker. A scoreboard keeps its own
// copy of the table store, the slot allocator and the base page register,
// predicts the reply of every accepted map or lookup command, and compares
// each reply in order. Directed commands cover the corner cases; random
// phases under four base page settings and three idling patterns follow.
// ----------------------------------------------------------------------------
module page_table_map_walker_test;

  localparam int TABLE_PAGES     = 64;
  localparam int WATCHDOG_LIMIT  = 150000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int POOL_DEPTH      = 48;

  localparam logic [63:0]                VA_TOP   = 64'h40_0000_0000;
  localparam logic [ptw_pkg::VA_W-1:0]   VA_TOP39 = 39'h40_0000_0000;
  localparam logic [ptw_pkg::PPN_W-1:0]  PPN_TOP  = 44'hFFF_FFFF_FFFF;

  typedef struct {
    logic                        command;
    logic [ptw_pkg::VA_W-1:0]    va;
    logic [ptw_pkg::SIZE_W-1:0]  size_bytes;
    logic [ptw_pkg::PA_W-1:0]    pa;
    logic [ptw_pkg::PERM_W-1:0]  perm;
  } walk_cmd_t;

  typedef struct {
    logic [ptw_pkg::STATUS_W-1:0] status;
    logic [ptw_pkg::LEAF_W-1:0]   leaf_entry;
  } walk_reply_t;

  class reply_board;
    logic [63:0]               table_mem [TABLE_PAGES*ptw_pkg::ENTRIES];
    int unsigned               next_slot;
    logic [ptw_pkg::PPN_W-1:0] base_page;
    walk_reply_t               expected_replies [$];
    int unsigned               errors;
    int unsigned               n_map;
    int unsigned               n_lookup;
    int unsigned               n_checked;
    int unsigned               status_seen [8];

    function new();
      foreach (table_mem[i]) table_mem[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      next_slot = 1;
      base_page = '0;
      errors    = 0;
      n_map     = 0;
      n_lookup  = 0;
      n_checked = 0;
    endfunction

    // descend from the root; with grow set, missing directories are allocated
    function logic [ptw_pkg::STATUS_W-1:0] walk_to_leaf(logic [63:0] addr, bit grow,
                                                        output int unsigned leaf_at);
      int unsigned               slot;
      int unsigned               at;
      logic [63:0]               entry;
      logic [ptw_pkg::PPN_W-1:0] span;
      logic [ptw_pkg::PPN_W-1:0] fresh_ppn;
      leaf_at = 0;
      slot = 0;
      if (addr >= VA_TOP) return ptw_pkg::ST_VA_RANGE;
      for (int lv = 2; lv > 0; lv--) begin
        at = slot * ptw_pkg::ENTRIES + int'((addr >> (12 + 9 * lv)) & 64'h1ff);
        entry = table_mem[at];
        if (entry[0]) begin
          // pointer may be stale after a base page change
          if (entry[53:10] < base_page) return ptw_pkg::ST_NO_PAGES;
          span = entry[53:10] - base_page;
          if (span >= TABLE_PAGES) return ptw_pkg::ST_NO_PAGES;
          slot = int'(span);
        end else begin
          if (!grow) return ptw_pkg::ST_NOT_MAPPED;
          if (next_slot >= TABLE_PAGES) return ptw_pkg::ST_NO_PAGES;
          for (int i = 0; i < ptw_pkg::ENTRIES; i++)
            table_mem[next_slot * ptw_pkg::ENTRIES + i] = '0;
          fresh_ppn = base_page + 44'(next_slot);
          table_mem[at] = {10'b0, fresh_ppn, 10'b0} | 64'd1;
          slot = next_slot;
          next_slot++;
        end
      end
      leaf_at = slot * ptw_pkg::ENTRIES + int'(addr[20:12]);
      return ptw_pkg::ST_OK;
    endfunction

    function void note_command(walk_cmd_t c);
      walk_reply_t              r;
      int unsigned              at;
      logic [63:0]              addr;
      logic [63:0]              last_page;
      logic [ptw_pkg::PA_W-1:0] phys;
      r.status = ptw_pkg::ST_OK;
      r.leaf_entry = '0;
      if (c.command == ptw_pkg::CMD_LOOKUP) begin
        n_lookup++;
        r.status = walk_to_leaf({25'b0, c.va}, 1'b0, at);
        if (r.status == ptw_pkg::ST_OK) begin
          if (table_mem[at][0]) r.leaf_entry = table_mem[at][ptw_pkg::LEAF_W-1:0];
          else r.status = ptw_pkg::ST_NOT_MAPPED;
        end
      end else begin
        n_map++;
        if (c.size_bytes == '0) begin
          r.status = ptw_pkg::ST_ZERO_SIZE;
        end else begin
          addr = {25'b0, c.va} & ~64'hfff;
          last_page = ({25'b0, c.va} + {25'b0, c.size_bytes} - 64'd1) & ~64'hfff;
          phys = c.pa;
          forever begin
            r.status = walk_to_leaf(addr, 1'b1, at);
            if (r.status != ptw_pkg::ST_OK) break;
            if (table_mem[at][0]) begin
              r.status = ptw_pkg::ST_MAPPED;
              break;
            end
            table_mem[at] = {10'b0, phys[ptw_pkg::PA_W-1:12], 10'b0} | {54'b0, c.perm}
                          | 64'd1;
            if (addr == last_page) break;
            addr += 64'h1000;
            phys += 56'h1000;
          end
        end
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [ptw_pkg::STATUS_W-1:0] status,
                              logic [ptw_pkg::LEAF_W-1:0] leaf);
      walk_reply_t want;
      n_checked++;
      status_seen[status]++;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with nothing outstanding, status %0d leaf %h",
                 $time, status, leaf);
        return;
      end
      want = expected_replies.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, status);
      end
      if (leaf !== want.leaf_entry) begin
        errors++;
        $display("%0t: leaf_entry mismatch: expected %h, actual %h",
                 $time, want.leaf_entry, leaf);
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [ptw_pkg::PPN_W-1:0] cfg_wdata_i;

  ptw_cmd_if cmd_ch ();
  ptw_rsp_if rsp_ch ();

  page_table_map_walker #(
    .TABLE_PAGES (TABLE_PAGES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_ch),
    .rsp_o       (rsp_ch)
  );

  reply_board board = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned fresh_pct = 8;
  bit          hold_armed = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [ptw_pkg::VA_W-1:0] region_pool [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: checks replies, idles at random, and holds off once on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) board.check_reply(rsp_ch.status, rsp_ch.leaf_entry);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic offer(input walk_cmd_t c);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= c.command;
    cmd_ch.va         <= c.va;
    cmd_ch.size_bytes <= c.size_bytes;
    cmd_ch.pa         <= c.pa;
    cmd_ch.perm       <= c.perm;
    do @(posedge clk_i); while (!cmd_ch.ready);
    board.note_command(c);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  task automatic offer_fields(input logic command, input logic [ptw_pkg::VA_W-1:0] va,
                              input logic [ptw_pkg::SIZE_W-1:0] size_bytes,
                              input logic [ptw_pkg::PA_W-1:0] pa,
                              input logic [ptw_pkg::PERM_W-1:0] perm);
    walk_cmd_t c;
    c.command    = command;
    c.va         = va;
    c.size_bytes = size_bytes;
    c.pa         = pa;
    c.perm       = perm;
    offer(c);
  endtask

  // the register is only touched with nothing in flight
  task automatic set_table_base(input logic [ptw_pkg::PPN_W-1:0] value);
    cmd_ch.valid <= 1'b0;
    while (board.expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.base_page = value;
  endtask

  function automatic walk_cmd_t random_command();
    walk_cmd_t                c;
    int unsigned              pick;
    bit                       near_top;
    logic [63:0]              wide_va;
    logic [63:0]              wide_size;
    logic [63:0]              wide_pa;
    logic [ptw_pkg::VA_W-1:0] base_va;
    wide_va   = {$urandom, $urandom};
    wide_size = {$urandom, $urandom};
    wide_pa   = {$urandom, $urandom};
    near_top  = 1'b0;
    c.command = ($urandom_range(0, 99) < 55) ? ptw_pkg::CMD_MAP : ptw_pkg::CMD_LOOKUP;
    c.pa      = wide_pa[ptw_pkg::PA_W-1:0];
    if ($urandom_range(0, 9) == 0)
      c.pa = {PPN_TOP - 44'($urandom_range(0, 3)), 12'($urandom)};
    c.perm = 10'($urandom);
    if ($urandom_range(0, 15) == 0) c.size_bytes = VA_TOP39;
    else c.size_bytes = {1'b0, wide_size[37:0]};
    pick = $urandom_range(0, 99);
    if (pick < fresh_pct) begin
      c.va = {1'b0, wide_va[37:0]};
      if (c.command == ptw_pkg::CMD_MAP) begin
        region_pool.push_back({c.va[ptw_pkg::VA_W-1:12], 12'b0});
        if (region_pool.size() > POOL_DEPTH) void'(region_pool.pop_front());
      end
    end else if (pick < fresh_pct + 4) begin
      // rejected outright, so any size is safe
      c.va = wide_va[ptw_pkg::VA_W-1:0] | VA_TOP39;
      near_top = 1'b1;
    end else if (pick < fresh_pct + 8) begin
      // a few pages below the limit; a long range stops there
      c.va = VA_TOP39 - 39'($urandom_range(1, 4)) * 39'h1000 + 39'($urandom_range(0, 4095));
      near_top = 1'b1;
    end else begin
      base_va = region_pool[$urandom_range(0, region_pool.size() - 1)];
      c.va = base_va + 39'($urandom_range(0, 15)) * 39'h1000 + 39'($urandom_range(0, 4095));
    end
    if (c.command == ptw_pkg::CMD_MAP && !near_top) begin
      if ($urandom_range(0, 99) < 4) c.size_bytes = '0;
      else c.size_bytes = 39'($urandom_range(1, 16384));
    end
    return c;
  endfunction

  task automatic run_phase(input int unsigned tx, input int unsigned rx,
                           input int unsigned fresh, input bit with_hold);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    fresh_pct   = fresh;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (with_hold && n == 60) hold_armed = 1'b1;
      offer(random_command());
    end
  endtask

  task automatic run_directed();
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h0, 39'h0, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_MAP, 39'h5000, 39'h0, 56'h1234_5000, 10'h3ff);
    // physical address wraps after the first page
    offer_fields(ptw_pkg::CMD_MAP, 39'h1000, 39'h3000, 56'hFF_FFFF_FFFF_F000, 10'h3fe);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h1000, 39'h7F_FFFF_FFFF, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h3fff, 39'h0, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h0, 39'h0, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_MAP, 39'h2abc, 39'h1, 56'h0, 10'h1);
    offer_fields(ptw_pkg::CMD_MAP, VA_TOP39, 39'h1, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h7F_FFFF_FFFF, 39'h0, 56'h0, 10'h0);
    // range runs into the va limit after two pages
    offer_fields(ptw_pkg::CMD_MAP, VA_TOP39 - 39'h2000, VA_TOP39, 56'h0, 10'h3ff);
    offer_fields(ptw_pkg::CMD_LOOKUP, VA_TOP39 - 39'h1000, 39'h0, 56'h0, 10'h0);
    // first page maps, second is taken: the first stays mapped
    offer_fields(ptw_pkg::CMD_MAP, 39'hfff, 39'h2, 56'hAB_CDEF_0123_4000, 10'h155);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h0, 39'h0, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_MAP, VA_TOP39 - 39'h1000, 39'h1, 56'h0, 10'h2aa);
    offer_fields(ptw_pkg::CMD_MAP, 39'h1ff000, 39'h2000, 56'h55_5555_5555_5000, 10'h0);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h200000, 39'h0, 56'h0, 10'h0);
    region_pool.push_back(39'h0);
    region_pool.push_back(39'h1ff000);
    region_pool.push_back(VA_TOP39 - 39'h4000);
    // old directory pointers go stale once the base moves
    set_table_base(44'h2);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h1000, 39'h0, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_LOOKUP, VA_TOP39 - 39'h1000, 39'h0, 56'h0, 10'h0);
    offer_fields(ptw_pkg::CMD_MAP, 39'h4000_0000, 39'h1000, 56'h3_0000_0000, 10'h3);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h4000_0000, 39'h0, 56'h0, 10'h0);
    set_table_base(PPN_TOP);
    offer_fields(ptw_pkg::CMD_MAP, 39'h8000_0000, 39'h1000, 56'h4_0000_0000, 10'h7);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h8000_0000, 39'h0, 56'h0, 10'h0);
    set_table_base(44'h0);
    offer_fields(ptw_pkg::CMD_LOOKUP, 39'h1000, 39'h0, 56'h0, 10'h0);
  endtask

  initial begin
    logic [ptw_pkg::PPN_W-1:0] mid_base;
    mid_base = {12'($urandom_range(1, 4095)), 32'($urandom)};
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.command    <= ptw_pkg::CMD_MAP;
    cmd_ch.va         <= '0;
    cmd_ch.size_bytes <= '0;
    cmd_ch.pa         <= '0;
    cmd_ch.perm       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    set_table_base(mid_base);
    run_phase(12, 62, 8, 1'b1);
    set_table_base(PPN_TOP);
    run_phase(62, 12, 8, 1'b0);
    set_table_base(44'h0);
    run_phase(0, 0, 8, 1'b0);
    // back to the first random base; more fresh regions to use up the store
    set_table_base(mid_base);
    run_phase(0, 0, 20, 1'b0);

    cmd_ch.valid <= 1'b0;
    while (board.expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d map and %0d lookup commands under four base page values, %0d replies",
             board.n_map, board.n_lookup, board.n_checked);
    $display("run: ok %0d, va range %0d, no pages %0d, mapped %0d, zero size %0d, %0s %0d",
             board.status_seen[ptw_pkg::ST_OK], board.status_seen[ptw_pkg::ST_VA_RANGE],
             board.status_seen[ptw_pkg::ST_NO_PAGES], board.status_seen[ptw_pkg::ST_MAPPED],
             board.status_seen[ptw_pkg::ST_ZERO_SIZE], "not mapped",
             board.status_seen[ptw_pkg::ST_NOT_MAPPED]);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ptw_pkg.sv
hdl/ptw_if.sv
hdl/ptw_alu.sv
hdl/ptw_store.sv
hdl/page_table_map_walker.sv
test/page_table_map_walker_test.sv
